/* hdl/rau_pkg.sv */
package rau_pkg;

   // Default operand width; the top level may narrow it.
   localparam int VALUE_BITS_DEF = 32;

   // Fixed field widths of the stream payload.
   localparam int FUNC_BITS  = 4;
   localparam int FIELD_BITS = 32;
   localparam int DEN_BITS   = 31;
   localparam int REQ_BITS   = 136;
   localparam int RSP_BITS   = 72;

   // Operation codes.
   localparam logic [FUNC_BITS-1:0] FN_ADD = 4'd0;
   localparam logic [FUNC_BITS-1:0] FN_SUB = 4'd1;
   localparam logic [FUNC_BITS-1:0] FN_MUL = 4'd2;
   localparam logic [FUNC_BITS-1:0] FN_DIV = 4'd3;
   localparam logic [FUNC_BITS-1:0] FN_RED = 4'd4;
   localparam logic [FUNC_BITS-1:0] FN_NEG = 4'd5;
   localparam logic [FUNC_BITS-1:0] FN_INC = 4'd6;
   localparam logic [FUNC_BITS-1:0] FN_DEC = 4'd7;
   localparam logic [FUNC_BITS-1:0] FN_CMP = 4'd8;

   // Multiplier step selects.
   localparam logic [1:0] MS_FIRST  = 2'd0;
   localparam logic [1:0] MS_SECOND = 2'd1;
   localparam logic [1:0] MS_DEN    = 2'd2;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic [1:0] mul_sel;
      logic       sum_en;
      logic       abs_en;
      logic       gcd_init;
      logic       gcd_step;
      logic       div_init;
      logic       div_step;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic early;
      logic is_cmp;
      logic gcd_done;
   } sts_type;

endpackage

/* hdl/rational_arithmetic_unit_core.sv */
// An accepted request passes through the multiply, sum, magnitude, binary GCD and divide
// phases before the response is loaded; the GCD loop runs until its first operand is zero.
// Errors and unknown operations go straight to the response, compare stops after the sum.
// Throughput: one transaction at a time; the GCD loop and the bit-serial dividers set it.
// Reset: synchronous, active high; it clears the controller and the response valid.
module rational_arithmetic_unit_core #(
   parameter int VALUE_BITS = rau_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // Fields from bit 0 up: func[3:0], a_num[35:4], a_den[67:36], b_num[99:68],
   // b_den[131:100], zero fill [135:132].
   input  logic [rau_pkg::REQ_BITS-1:0]  req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // Fields from bit 0 up: res_num[31:0], res_den[62:32], div_zero[63], overflow[64],
   // is_less[65], is_equal[66], zero fill [71:67].
   output logic [rau_pkg::RSP_BITS-1:0]  rsp_tdata
);
   import rau_pkg::*;

   cmd_type              cmd;
   sts_type              sts;
   logic [FIELD_BITS-1:0] res_num;
   logic [DEN_BITS-1:0]   res_den;
   logic                  div_zero, overflow, is_less, is_equal;

   // The controller sequences multiply, sum, magnitude, GCD and divide phases.
   rau_control #(.VALUE_BITS(VALUE_BITS)) u_control (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the operands, the shared multiplier, the GCD unit, the
   // dividers and the response register, which keeps its value until it is taken.
   rau_datapath #(.VALUE_BITS(VALUE_BITS)) u_datapath (
      .clock    (clock),
      .func     (req_tdata[3:0]),
      .a_num    (req_tdata[35:4]),
      .a_den    (req_tdata[67:36]),
      .b_num    (req_tdata[99:68]),
      .b_den    (req_tdata[131:100]),
      .cmd      (cmd),
      .sts      (sts),
      .res_num  (res_num),
      .res_den  (res_den),
      .div_zero (div_zero),
      .overflow (overflow),
      .is_less  (is_less),
      .is_equal (is_equal)
   );

   assign rsp_tdata = {5'b0, is_equal, is_less, overflow, div_zero, res_den, res_num};

endmodule

/* hdl/rau_datapath.sv */
module rau_datapath #(
   parameter int VALUE_BITS = rau_pkg::VALUE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic [rau_pkg::FUNC_BITS-1:0]         func,
   input  logic [rau_pkg::FIELD_BITS-1:0]        a_num,
   input  logic [rau_pkg::FIELD_BITS-1:0]        a_den,
   input  logic [rau_pkg::FIELD_BITS-1:0]        b_num,
   input  logic [rau_pkg::FIELD_BITS-1:0]        b_den,
   input  rau_pkg::cmd_type                      cmd,
   output rau_pkg::sts_type                      sts,
   output logic [rau_pkg::FIELD_BITS-1:0]        res_num,
   output logic [rau_pkg::DEN_BITS-1:0]          res_den,
   output logic                                  div_zero,
   output logic                                  overflow,
   output logic                                  is_less,
   output logic                                  is_equal
);
   import rau_pkg::*;

   localparam int W  = VALUE_BITS;
   localparam int PW = 2 * VALUE_BITS;
   localparam int KW = $clog2(PW);
   localparam logic [PW-1:0] LIM = PW'(1) << (W - 1);

   logic [FUNC_BITS-1:0] func_ff, func_in;
   logic signed [W-1:0]  an_ff, ad_ff, bn_ff, bd_ff;
   logic signed [W-1:0]  an_in, ad_in, bn_in, bd_in;
   logic                 dz_ff, dz_in, badf_ff, badf_in;

   logic signed [W-1:0]  mul_a, mul_b;
   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] p1_ff, p2_ff, p3_ff, p1_in, p2_in, p3_in;

   logic signed [PW:0]   nv_ff, nv_in;
   logic signed [PW-1:0] dv_ff, dv_in;
   logic                 lt_ff, lt_in, eq_ff, eq_in;

   logic [PW-1:0]        nm_ff, nm_in, dm_ff, dm_in;
   logic                 neg_ff, neg_in;

   logic [PW-1:0]        x_ff, x_in, y_ff, y_in;
   logic [KW-1:0]        k_ff, k_in;

   logic [PW-1:0]        g_ff, g_in, qn_ff, qn_in, qd_ff, qd_in, rn_ff, rn_in, rd_ff, rd_in;
   logic [PW:0]          rn_t, rd_t;

   logic [FIELD_BITS-1:0] res_num_ff, res_num_in;
   logic [DEN_BITS-1:0]   res_den_ff, res_den_in;
   logic                  dzo_ff, dzo_in, ovo_ff, ovo_in, lto_ff, lto_in, eqo_ff, eqo_in;

   logic                  uses_b, fin_neg, fin_ovf;
   logic [PW-1:0]         fin_num;
   logic signed [W-1:0]   fin_narrow;
   logic signed [PW:0]    anx, adx, p1x, p2x;

   // Operand capture and early error detection.
   always_comb begin
      uses_b  = (func <= FN_DIV) || (func == FN_CMP);
      func_in = cmd.load ? func : func_ff;
      an_in   = cmd.load ? a_num[W-1:0] : an_ff;
      ad_in   = cmd.load ? a_den[W-1:0] : ad_ff;
      bn_in   = cmd.load ? b_num[W-1:0] : bn_ff;
      bd_in   = cmd.load ? b_den[W-1:0] : bd_ff;
      badf_in = cmd.load ? (func > FN_CMP) : badf_ff;
      dz_in   = cmd.load ? ((a_den[W-1:0] == '0) || (uses_b && (b_den[W-1:0] == '0))
                            || ((func == FN_DIV) && (b_num[W-1:0] == '0))) : dz_ff;
   end

   // Shared multiplier, one product per cycle.
   always_comb begin
      case (cmd.mul_sel)
         MS_FIRST: begin
            mul_a = an_ff;
            mul_b = (func_ff == FN_MUL) ? bn_ff : bd_ff;
         end
         MS_SECOND: begin
            mul_a = bn_ff;
            mul_b = ad_ff;
         end
         MS_DEN: begin
            mul_a = ad_ff;
            mul_b = (func_ff == FN_DIV) ? bn_ff : bd_ff;
         end
         default: begin
            mul_a = ad_ff;
            mul_b = bd_ff;
         end
      endcase
      prod  = PW'(mul_a) * PW'(mul_b);
      p1_in = (cmd.mul_en && cmd.mul_sel == MS_FIRST)  ? prod : p1_ff;
      p2_in = (cmd.mul_en && cmd.mul_sel == MS_SECOND) ? prod : p2_ff;
      p3_in = (cmd.mul_en && cmd.mul_sel == MS_DEN)    ? prod : p3_ff;
   end

   // Numerator and denominator in signed form, plus compare flags.
   always_comb begin
      anx = (PW+1)'(an_ff);
      adx = (PW+1)'(ad_ff);
      p1x = (PW+1)'(p1_ff);
      p2x = (PW+1)'(p2_ff);
      nv_in = nv_ff;
      dv_in = dv_ff;
      lt_in = lt_ff;
      eq_in = eq_ff;
      if (cmd.sum_en) begin
         case (func_ff)
            FN_ADD:  nv_in = p1x + p2x;
            FN_SUB:  nv_in = p1x - p2x;
            FN_MUL:  nv_in = p1x;
            FN_DIV:  nv_in = p1x;
            FN_RED:  nv_in = anx;
            FN_NEG:  nv_in = -anx;
            FN_INC:  nv_in = anx + adx;
            FN_DEC:  nv_in = anx - adx;
            default: nv_in = '0;
         endcase
         dv_in = (func_ff <= FN_DIV) ? p3_ff : PW'(ad_ff);
         lt_in = (ad_ff[W-1] ^ bd_ff[W-1]) ? (p2_ff < p1_ff) : (p1_ff < p2_ff);
         eq_in = (p1_ff == p2_ff);
      end
   end

   // Magnitudes and result sign.
   always_comb begin
      nm_in  = nm_ff;
      dm_in  = dm_ff;
      neg_in = neg_ff;
      if (cmd.abs_en) begin
         nm_in  = nv_ff[PW] ? PW'(-nv_ff) : nv_ff[PW-1:0];
         dm_in  = dv_ff[PW-1] ? PW'(-dv_ff) : dv_ff;
         neg_in = nv_ff[PW] ^ dv_ff[PW-1];
      end
   end

   // Binary GCD, one step per cycle.
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      k_in = k_ff;
      if (cmd.gcd_init) begin
         x_in = nm_ff;
         y_in = dm_ff;
         k_in = '0;
      end else if (cmd.gcd_step) begin
         if (!x_ff[0] && !y_ff[0]) begin
            x_in = x_ff >> 1;
            y_in = y_ff >> 1;
            k_in = k_ff + KW'(1);
         end else if (!x_ff[0]) begin
            x_in = x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_in = y_ff >> 1;
         end else if (x_ff >= y_ff) begin
            x_in = (x_ff - y_ff) >> 1;
         end else begin
            y_in = (y_ff - x_ff) >> 1;
         end
      end
   end

   // Two restoring dividers sharing the divisor, one quotient bit per cycle.
   always_comb begin
      rn_t  = {rn_ff, qn_ff[PW-1]};
      rd_t  = {rd_ff, qd_ff[PW-1]};
      g_in  = g_ff;
      qn_in = qn_ff;
      qd_in = qd_ff;
      rn_in = rn_ff;
      rd_in = rd_ff;
      if (cmd.div_init) begin
         g_in  = y_ff << k_ff;
         qn_in = nm_ff;
         qd_in = dm_ff;
         rn_in = '0;
         rd_in = '0;
      end else if (cmd.div_step) begin
         if (rn_t >= {1'b0, g_ff}) begin
            rn_in = PW'(rn_t - {1'b0, g_ff});
            qn_in = {qn_ff[PW-2:0], 1'b1};
         end else begin
            rn_in = rn_t[PW-1:0];
            qn_in = {qn_ff[PW-2:0], 1'b0};
         end
         if (rd_t >= {1'b0, g_ff}) begin
            rd_in = PW'(rd_t - {1'b0, g_ff});
            qd_in = {qd_ff[PW-2:0], 1'b1};
         end else begin
            rd_in = rd_t[PW-1:0];
            qd_in = {qd_ff[PW-2:0], 1'b0};
         end
      end
   end

   // Final range check and result register.
   always_comb begin
      fin_neg    = neg_ff && (qn_ff != '0);
      fin_ovf    = (qd_ff >= LIM) || (fin_neg ? (qn_ff > LIM) : (qn_ff >= LIM));
      fin_num    = fin_neg ? -qn_ff : qn_ff;
      fin_narrow = fin_num[W-1:0];
      res_num_in = res_num_ff;
      res_den_in = res_den_ff;
      dzo_in     = dzo_ff;
      ovo_in     = ovo_ff;
      lto_in     = lto_ff;
      eqo_in     = eqo_ff;
      if (cmd.out_load) begin
         res_num_in = '0;
         res_den_in = DEN_BITS'(1);
         dzo_in     = 1'b0;
         ovo_in     = 1'b0;
         lto_in     = 1'b0;
         eqo_in     = 1'b0;
         if (badf_ff) begin
            res_num_in = '0;
         end else if (dz_ff) begin
            dzo_in = 1'b1;
         end else if (func_ff == FN_CMP) begin
            lto_in = lt_ff;
            eqo_in = eq_ff;
         end else if (fin_ovf) begin
            ovo_in = 1'b1;
         end else begin
            res_num_in = FIELD_BITS'(fin_narrow);
            res_den_in = DEN_BITS'(qd_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      an_ff      <= an_in;
      ad_ff      <= ad_in;
      bn_ff      <= bn_in;
      bd_ff      <= bd_in;
      dz_ff      <= dz_in;
      badf_ff    <= badf_in;
      p1_ff      <= p1_in;
      p2_ff      <= p2_in;
      p3_ff      <= p3_in;
      nv_ff      <= nv_in;
      dv_ff      <= dv_in;
      lt_ff      <= lt_in;
      eq_ff      <= eq_in;
      nm_ff      <= nm_in;
      dm_ff      <= dm_in;
      neg_ff     <= neg_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      k_ff       <= k_in;
      g_ff       <= g_in;
      qn_ff      <= qn_in;
      qd_ff      <= qd_in;
      rn_ff      <= rn_in;
      rd_ff      <= rd_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      dzo_ff     <= dzo_in;
      ovo_ff     <= ovo_in;
      lto_ff     <= lto_in;
      eqo_ff     <= eqo_in;
   end

   assign sts.early    = dz_ff || badf_ff;
   assign sts.is_cmp   = (func_ff == FN_CMP);
   assign sts.gcd_done = (x_ff == '0);

   assign res_num  = res_num_ff;
   assign res_den  = res_den_ff;
   assign div_zero = dzo_ff;
   assign overflow = ovo_ff;
   assign is_less  = lto_ff;
   assign is_equal = eqo_ff;

endmodule

/* hdl/rau_control.sv */
module rau_control #(
   parameter int VALUE_BITS = rau_pkg::VALUE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   output logic             out_valid,
   input  logic             out_ready,
   input  rau_pkg::sts_type sts,
   output rau_pkg::cmd_type cmd
);
   import rau_pkg::*;

   localparam int PW = 2 * VALUE_BITS;
   localparam int CW = $clog2(PW);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_MUL    = 9'b000000010,
      ST_SUM    = 9'b000000100,
      ST_ABS    = 9'b000001000,
      ST_GINIT  = 9'b000010000,
      ST_GCD    = 9'b000100000,
      ST_DINIT  = 9'b001000000,
      ST_DIV    = 9'b010000000,
      ST_FINISH = 9'b100000000
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.mul_sel = cnt_ff[1:0];
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (sts.early) begin
               state_in = ST_FINISH;
            end else begin
               cmd.mul_en = 1'b1;
               if (cnt_ff[1:0] == MS_DEN) begin
                  cnt_in   = '0;
                  state_in = ST_SUM;
               end else begin
                  cnt_in = cnt_ff + CW'(1);
               end
            end
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = sts.is_cmp ? ST_FINISH : ST_ABS;
         end
         ST_ABS: begin
            cmd.abs_en = 1'b1;
            state_in   = ST_GINIT;
         end
         ST_GINIT: begin
            cmd.gcd_init = 1'b1;
            state_in     = ST_GCD;
         end
         ST_GCD: begin
            if (sts.gcd_done) begin
               state_in = ST_DINIT;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DINIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CW'(1);
            if (cnt_ff == CW'(PW - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!valid_ff || out_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = valid_ff;

endmodule

/* hdl/rau_checker.sv */
module rau_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic [rau_pkg::REQ_BITS-1:0] req_tdata,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [rau_pkg::RSP_BITS-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[62:32] != 31'd0)
      else $error("zero denominator in response");

   a_err_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[63] && rsp_tdata[64]))
      else $error("division by zero and overflow both set");

   a_err_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[63] || rsp_tdata[64]) |->
         rsp_tdata[31:0] == 32'd0 && rsp_tdata[62:32] == 31'd1)
      else $error("error response is not zero over one");

   a_cmp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[65] && rsp_tdata[66]))
      else $error("less and equal both set");

endmodule

bind rational_arithmetic_unit_core rau_checker u_checker (.*);

/* test/rational_arithmetic_unit_core_tb.sv */
`timescale 1ns / 1ps

// Expected-response store for the rational unit: one response per request, in order.
class rau_scoreboard;
   logic [66:0] pending_rsp[$];
   int          errors = 0;

   // Reduce num/den (magnitudes) to lowest terms and pack a value or overflow response.
   function automatic logic [66:0] reduce_value(bit nn, logic [63:0] nm, bit dn,
                                                logic [63:0] dm);
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] t;
      logic [63:0] lim;
      bit          neg;
      x = nm;
      y = dm;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      nm = nm / x;
      dm = dm / x;
      lim = 64'd1 << 31;
      neg = (nm != 0) && (nn != dn);
      if (dm >= lim || (neg ? nm > lim : nm >= lim))
         return {4'b0010, 31'd1, 32'd0};
      return {4'b0000, dm[30:0], neg ? (32'd0 - nm[31:0]) : nm[31:0]};
   endfunction

   // Predict the response of one request.
   function automatic logic [66:0] predict_rsp(logic [3:0] func, logic signed [31:0] an,
                                              logic signed [31:0] ad, logic signed [31:0] bn,
                                              logic signed [31:0] bd);
      logic signed [65:0] nv;
      logic signed [65:0] dv;
      logic signed [65:0] lhs;
      logic signed [65:0] rhs;
      bit                 uses_b;
      bit                 flip;
      bit                 lt;
      uses_b = func <= rau_pkg::FN_DIV || func == rau_pkg::FN_CMP;
      if (func > rau_pkg::FN_CMP)
         return {4'b0000, 31'd1, 32'd0};
      if (ad == 0 || (uses_b && bd == 0) || (func == rau_pkg::FN_DIV && bn == 0))
         return {4'b0001, 31'd1, 32'd0};
      dv = 66'(ad);
      case (func)
         rau_pkg::FN_ADD: begin
            nv = 66'(an) * bd + 66'(bn) * ad;
            dv = 66'(ad) * bd;
         end
         rau_pkg::FN_SUB: begin
            nv = 66'(an) * bd - 66'(bn) * ad;
            dv = 66'(ad) * bd;
         end
         rau_pkg::FN_MUL: begin
            nv = 66'(an) * bn;
            dv = 66'(ad) * bd;
         end
         rau_pkg::FN_DIV: begin
            nv = 66'(an) * bd;
            dv = 66'(ad) * bn;
         end
         rau_pkg::FN_RED: nv = 66'(an);
         rau_pkg::FN_NEG: nv = -66'(an);
         rau_pkg::FN_INC: nv = 66'(an) + ad;
         rau_pkg::FN_DEC: nv = 66'(an) - ad;
         default: begin
            lhs = 66'(an) * bd;
            rhs = 66'(bn) * ad;
            flip = (ad < 0) != (bd < 0);
            lt = flip ? (rhs < lhs) : (lhs < rhs);
            return {lhs == rhs, lt, 2'b00, 31'd1, 32'd0};
         end
      endcase
      return reduce_value(nv < 0, 64'(nv < 0 ? -nv : nv), dv < 0, 64'(dv < 0 ? -dv : dv));
   endfunction

   function void note_request(logic [135:0] data);
      pending_rsp.push_back(predict_rsp(data[3:0], data[35:4], data[67:36], data[99:68],
                                        data[131:100]));
   endfunction

   function void check_response(logic [71:0] data);
      logic [66:0] exp_rsp;
      if (pending_rsp.size() == 0) begin
         $display("%0t: unexpected response %h", $time, data);
         errors++;
         return;
      end
      exp_rsp = pending_rsp.pop_front();
      if (data[31:0] !== exp_rsp[31:0])
         $display("%0t: res_num expected %h actual %h", $time, exp_rsp[31:0], data[31:0]);
      if (data[62:32] !== exp_rsp[62:32])
         $display("%0t: res_den expected %h actual %h", $time, exp_rsp[62:32], data[62:32]);
      if (data[63] !== exp_rsp[63])
         $display("%0t: div_zero expected %b actual %b", $time, exp_rsp[63], data[63]);
      if (data[64] !== exp_rsp[64])
         $display("%0t: overflow expected %b actual %b", $time, exp_rsp[64], data[64]);
      if (data[65] !== exp_rsp[65])
         $display("%0t: is_less expected %b actual %b", $time, exp_rsp[65], data[65]);
      if (data[66] !== exp_rsp[66])
         $display("%0t: is_equal expected %b actual %b", $time, exp_rsp[66], data[66]);
      if (data[66:0] !== exp_rsp)
         errors++;
   endfunction
endclass

module rational_arithmetic_unit_core_tb;
   import rau_pkg::*;

   localparam int RANDOM_ITEMS = 1200;
   // Idle limit for the watchdog, well above the worst-case transaction.
   localparam int WATCHDOG_LIMIT = 5000;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_BITS-1:0] rsp_tdata;

   rau_scoreboard scoreboard = new();
   bit            stimulus_done = 0;
   int            idle_cycles = 0;

   rational_arithmetic_unit_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Pick an operand value that favors the corners: zero, one, minus one and the limits.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'hFFFF_FFFF;
         3: return 32'h7FFF_FFFF;
         4: return 32'h8000_0000;
         5: return 32'($signed($urandom_range(0, 40)) - 20);
         6: return 32'($urandom_range(0, 2000)) * 32'($urandom_range(1, 300));
         default: return $urandom();
      endcase
   endfunction

   // Send one request transaction; valid stays high until the block takes it.
   // Valid drops only for an idle gap, so back-to-back requests keep it high.
   task automatic send_request(logic [3:0] func, logic [31:0] an, logic [31:0] ad,
                               logic [31:0] bn, logic [31:0] bd);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, bd, bn, ad, an, func};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Log each accepted request with the prediction of its response.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         scoreboard.note_request(req_tdata);
   end

   // The response side stalls at random; each accepted response is checked.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, 3);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         scoreboard.check_response(rsp_tdata);
      end
   end

   // Watchdog: count cycles without any transaction on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL rational_arithmetic_unit_core");
         $finish;
      end
   end

   initial begin
      logic [3:0] func;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: every operation, the extremes and the division-by-zero cases.
      send_request(FN_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
      send_request(FN_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
      send_request(FN_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
      send_request(FN_DIV, 32'd3, 32'd4, 32'd0, 32'd5);
      send_request(FN_DIV, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd2, 32'h8000_0000);
      send_request(FN_RED, 32'd6, 32'hFFFF_FFF7, 32'd0, 32'd0);
      send_request(FN_RED, 32'd0, 32'h8000_0000, 32'd5, 32'd0);
      send_request(FN_NEG, 32'h8000_0000, 32'd1, 32'd0, 32'd0);
      send_request(FN_NEG, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd0);
      send_request(FN_INC, 32'h7FFF_FFFF, 32'd1, 32'd0, 32'd0);
      send_request(FN_DEC, 32'h8000_0000, 32'd1, 32'd0, 32'd0);
      send_request(FN_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
      send_request(FN_ADD, 32'd1, 32'd1, 32'd1, 32'd0);
      send_request(FN_CMP, 32'd1, 32'd2, 32'd2, 32'd4);
      send_request(FN_CMP, 32'd1, 32'hFFFF_FFFE, 32'd1, 32'd2);
      send_request(FN_CMP, 32'd1, 32'd0, 32'd1, 32'd2);
      send_request(FN_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(4'd9, 32'd1, 32'd1, 32'd1, 32'd1);
      send_request(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      req_tvalid <= 1'b0;

      // Hold off until every expected response has come back.
      while (scoreboard.pending_rsp.size() != 0) @(posedge clock);

      // Random part; unknown codes show up only now and then.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         func = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 8));
         send_request(func, pick_value(), pick_value(), pick_value(), pick_value());
      end
      req_tvalid <= 1'b0;
      stimulus_done = 1;
   end

   // End of run: drain, let the latency pass, then report.
   initial begin
      wait (stimulus_done);
      while (scoreboard.pending_rsp.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (scoreboard.errors == 0 && scoreboard.pending_rsp.size() == 0)
         $display("PASS rational_arithmetic_unit_core");
      else
         $display("FAIL rational_arithmetic_unit_core");
      $finish;
   end
endmodule
